[src/bfu_pkg.sv]
// Shared constants, register indexes and the color blend function of the upscaler.
package bfu_pkg;

  localparam int COORD_W    = 12;
  localparam int PIX_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int SRC_REG_W  = 9;
  localparam int TGT_REG_W  = 13;
  localparam int WEIGHT_W   = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_HEIGHT = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // One 8-bit channel: (a*(256-w) + b*w + 128) >> 8, never above 16 bits.
  function automatic logic [7:0] blend8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [WEIGHT_W-1:0] w);
    logic [16:0] s;
    s = 17'(a) * 17'(9'd256 - 9'(w)) + 17'(b) * 17'(w) + 17'd128;
    return s[15:8];
  endfunction

  function automatic logic [PIX_W-1:0] blend24(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b,
                                               input logic [WEIGHT_W-1:0] w);
    logic [PIX_W-1:0] r;
    for (int c = 0; c < 3; c++) begin
      r[8*c +: 8] = blend8(a[8*c +: 8], b[8*c +: 8], w);
    end
    return r;
  endfunction

endpackage

[src/bfu_locate.sv]
// Source position of one axis: multiply, offset and a pipelined restoring divider.
module bfu_locate #(
  parameter int MAX_SRC  = 256,
  parameter int MAX_TGT  = 4096,
  parameter int DIV_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [bfu_pkg::COORD_W-1:0]         pos_i,
  input  logic [$clog2(MAX_SRC+1)-1:0]        src_i,
  input  logic [$clog2(MAX_TGT+1)-1:0]        tgt_i,
  output logic [$clog2(MAX_SRC)-1:0]          lo_o,
  output logic                                edge_o,
  output logic [bfu_pkg::WEIGHT_W-1:0]        weight_o
);

  localparam int SRC_W = $clog2(MAX_SRC+1);
  localparam int TGT_W = $clog2(MAX_TGT+1);
  localparam int LO_W  = $clog2(MAX_SRC);
  localparam int PW    = bfu_pkg::COORD_W + 1 + SRC_W;
  localparam int DW    = TGT_W + 1;
  localparam int NW    = PW + 9;
  localparam int CW    = ((NW > DW + DIV_BITS) ? NW : DW + DIV_BITS) + 1;
  localparam int NS    = DIV_BITS / 2;
  localparam int IW    = DIV_BITS - bfu_pkg::WEIGHT_W;
  localparam int EW    = ((IW > SRC_W) ? IW : SRC_W) + 1;

  logic [PW-1:0]       prod_q;
  logic [CW-1:0]       dd;
  logic [CW-1:0]       np;
  logic                sat;
  logic [CW-1:0]       rem_q [NS+1];
  logic [DIV_BITS-1:0] quo_q [NS+1];
  logic                sat_q [NS+1];
  logic [IW-1:0]       ip;
  logic [SRC_W-1:0]    srcm1;
  logic                big;
  logic [LO_W-1:0]     lo_q;
  logic                edge_q;
  logic [bfu_pkg::WEIGHT_W-1:0] w_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PW'({pos_i, 1'b1}) * PW'(src_i);
    end
  end

  // Dividend is 256*num + T over divisor 2T, so the quotient carries the
  // integer position and the rounded Q8 weight together.
  assign dd = CW'({tgt_i, 1'b0});
  always_comb begin
    np  = '0;
    sat = 1'b0;
    if (prod_q > PW'(tgt_i)) begin
      np  = (CW'(prod_q - PW'(tgt_i)) << 8) + CW'(tgt_i);
      sat = np >= (dd << DIV_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= np;
      quo_q[0] <= '0;
      sat_q[0] <= sat;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_div
    logic [CW-1:0]       r_b;
    logic [DIV_BITS-1:0] q_b;
    always_comb begin
      r_b = rem_q[s];
      q_b = quo_q[s];
      if (r_b >= (dd << (DIV_BITS-1-2*s))) begin
        r_b = r_b - (dd << (DIV_BITS-1-2*s));
        q_b[DIV_BITS-1-2*s] = 1'b1;
      end
      if (r_b >= (dd << (DIV_BITS-2-2*s))) begin
        r_b = r_b - (dd << (DIV_BITS-2-2*s));
        q_b[DIV_BITS-2-2*s] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= r_b;
        quo_q[s+1] <= q_b;
        sat_q[s+1] <= sat_q[s];
      end
    end
  end

  // A weight of 256 shows up as the next integer with weight zero, which
  // selects the same source pixel.
  assign ip    = quo_q[NS][DIV_BITS-1:bfu_pkg::WEIGHT_W];
  assign srcm1 = src_i - SRC_W'(1);
  assign big   = sat_q[NS] || (EW'(ip) >= EW'(srcm1));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q   <= big ? LO_W'(srcm1) : LO_W'(ip);
      edge_q <= big;
      w_q    <= big ? '0 : quo_q[NS][bfu_pkg::WEIGHT_W-1:0];
    end
  end

  assign lo_o     = lo_q;
  assign edge_o   = edge_q;
  assign weight_o = w_q;

endmodule

[src/bfu_store.sv]
// Four-bank frame store split by column and row parity: four neighbors per enabled cycle.
module bfu_store #(
  parameter int MAX_W = 256,
  parameter int MAX_H = 256
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic                           we_i,
  input  logic [$clog2(MAX_W)-1:0]       wx_i,
  input  logic [$clog2(MAX_H)-1:0]       wy_i,
  input  logic [bfu_pkg::PIX_W-1:0]      wdata_i,
  input  logic [$clog2(MAX_W)-1:0]       x_lo_i,
  input  logic                           x_edge_i,
  input  logic [$clog2(MAX_H)-1:0]       y_lo_i,
  input  logic                           y_edge_i,
  output logic [bfu_pkg::PIX_W-1:0]      p00_o,
  output logic [bfu_pkg::PIX_W-1:0]      p10_o,
  output logic [bfu_pkg::PIX_W-1:0]      p01_o,
  output logic [bfu_pkg::PIX_W-1:0]      p11_o
);

  localparam int XB    = $clog2(MAX_W);
  localparam int YB    = $clog2(MAX_H);
  localparam int HW    = (MAX_W + 1) / 2;
  localparam int HH    = (MAX_H + 1) / 2;
  localparam int DEPTH = HW * HH;
  localparam int AW    = $clog2(DEPTH);

  logic [XB:0]   x_inc;
  logic [YB:0]   y_inc;
  logic [XB-2:0] x_e, x_o;
  logic [YB-2:0] y_e, y_o;
  logic [AW-1:0] wa;
  logic [1:0]    wbank;
  logic [3:0][bfu_pkg::PIX_W-1:0] rd_q;
  logic          xp_q, yp_q, xe_q, ye_q;
  logic          xh, yh;

  // The even bank holds column lo or lo+1, the odd bank the other one.
  assign x_inc = {1'b0, x_lo_i} + (XB+1)'(1);
  assign y_inc = {1'b0, y_lo_i} + (YB+1)'(1);
  assign x_o   = x_lo_i[XB-1:1];
  assign y_o   = y_lo_i[YB-1:1];
  assign x_e   = x_edge_i ? x_lo_i[XB-1:1] : x_inc[XB-1:1];
  assign y_e   = y_edge_i ? y_lo_i[YB-1:1] : y_inc[YB-1:1];

  assign wa    = AW'(wy_i[YB-1:1]) * AW'(HW) + AW'(wx_i[XB-1:1]);
  assign wbank = {wy_i[0], wx_i[0]};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam int RP = b / 2;
    localparam int CP = b % 2;
    logic [bfu_pkg::PIX_W-1:0] mem [DEPTH];
    logic [AW-1:0]             ra;
    assign ra = AW'((RP != 0) ? y_o : y_e) * AW'(HW) + AW'((CP != 0) ? x_o : x_e);
    always_ff @(posedge clk_i) begin
      if (en_i && we_i && (wbank == 2'(b))) begin
        mem[wa] <= wdata_i;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rd_q[b] <= mem[ra];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xp_q <= x_lo_i[0];
      yp_q <= y_lo_i[0];
      xe_q <= x_edge_i;
      ye_q <= y_edge_i;
    end
  end

  // At a clamped edge the far neighbor is the near one again.
  assign xh = xe_q ? xp_q : ~xp_q;
  assign yh = ye_q ? yp_q : ~yp_q;

  assign p00_o = rd_q[{yp_q, xp_q}];
  assign p10_o = rd_q[{yp_q, xh}];
  assign p01_o = rd_q[{yh, xp_q}];
  assign p11_o = rd_q[{yh, xh}];

endmodule

[src/bfu_blend.sv]
// Two-stage bilinear mix: horizontal on both rows, then vertical.
module bfu_blend (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [bfu_pkg::PIX_W-1:0]      p00_i,
  input  logic [bfu_pkg::PIX_W-1:0]      p10_i,
  input  logic [bfu_pkg::PIX_W-1:0]      p01_i,
  input  logic [bfu_pkg::PIX_W-1:0]      p11_i,
  input  logic [bfu_pkg::WEIGHT_W-1:0]   wx_i,
  input  logic [bfu_pkg::WEIGHT_W-1:0]   wy_i,
  output logic [bfu_pkg::PIX_W-1:0]      pix_o
);

  logic [bfu_pkg::PIX_W-1:0]    top_q, bot_q, pix_q;
  logic [bfu_pkg::WEIGHT_W-1:0] wy_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      top_q <= bfu_pkg::blend24(p00_i, p10_i, wx_i);
      bot_q <= bfu_pkg::blend24(p01_i, p11_i, wx_i);
      wy_q  <= wy_i;
      pix_q <= bfu_pkg::blend24(top_q, bot_q, wy_q);
    end
  end

  assign pix_o = pix_q;

endmodule

[src/bilinear_frame_upscaler.sv]
// Top level of the bilinear frame upscaler: config registers, request pipeline and control.
//
// The block holds a source frame of up to MAX_SOURCE_WIDTH x MAX_SOURCE_HEIGHT RGB pixels
// and answers read requests with one pixel of a bilinear upscale to the configured target
// size. A request with opcode 0 writes a source pixel (ignored outside the configured source
// size) and returns nothing; opcode 1 returns one interpolated pixel. Requests are taken one
// per clock while the output does not stall; results come out in request order. The
// pipeline registers the product and the dividend, then each divider stage resolves two
// quotient bits, then the final clamp, the frame store read and the horizontal and vertical
// mixes. The store is split into four banks by column and row parity so the four neighbors
// are read in the same cycle. The whole pipeline stalls together only while a finished
// result waits at the output. The user must write configuration registers through the
// plain write port only while no request is in flight; the block does not enforce this.
// Written sizes are saturated to the supported range, source sizes from their low 9 bits.
module bilinear_frame_upscaler #(
  parameter int MAX_SOURCE_WIDTH  = 256,
  parameter int MAX_SOURCE_HEIGHT = 256,
  parameter int MAX_TARGET_SIZE   = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bfu_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bfu_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              opcode_i,
  input  logic [bfu_pkg::COORD_W-1:0]       coord_x_i,
  input  logic [bfu_pkg::COORD_W-1:0]       coord_y_i,
  input  logic [bfu_pkg::PIX_W-1:0]         pixel_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bfu_pkg::PIX_W-1:0]         pixel_out_o
);

  localparam int SWW   = $clog2(MAX_SOURCE_WIDTH + 1);
  localparam int SHW   = $clog2(MAX_SOURCE_HEIGHT + 1);
  localparam int TSW   = $clog2(MAX_TARGET_SIZE + 1);
  localparam int XB    = $clog2(MAX_SOURCE_WIDTH);
  localparam int YB    = $clog2(MAX_SOURCE_HEIGHT);
  localparam int QB    = ((XB > YB) ? XB : YB) + bfu_pkg::WEIGHT_W;
  localparam int DIV_BITS = QB + (QB % 2);
  localparam int LOC   = DIV_BITS / 2 + 3;
  localparam int SW_RST = (MAX_SOURCE_WIDTH < 256) ? MAX_SOURCE_WIDTH : 256;
  localparam int SH_RST = (MAX_SOURCE_HEIGHT < 256) ? MAX_SOURCE_HEIGHT : 256;
  localparam int TS_RST = (MAX_TARGET_SIZE < 256) ? MAX_TARGET_SIZE : 256;

  // Saturate a written size to 1..maxv.
  function automatic logic [15:0] sat_size(input logic [bfu_pkg::CFG_DATA_W-1:0] v,
                                           input int maxv);
    logic [15:0] r;
    r = 16'(v);
    if (r == 16'd0) begin
      r = 16'd1;
    end else if (32'(r) > maxv) begin
      r = 16'(maxv);
    end
    return r;
  endfunction

  logic [SWW-1:0] sw_q;
  logic [SHW-1:0] sh_q;
  logic [TSW-1:0] tw_q, th_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= SWW'(SW_RST);
      sh_q <= SHW'(SH_RST);
      tw_q <= TSW'(TS_RST);
      th_q <= TSW'(TS_RST);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bfu_pkg::REG_SRC_WIDTH: begin
          sw_q <= SWW'(sat_size(13'(cfg_wdata_i[bfu_pkg::SRC_REG_W-1:0]), MAX_SOURCE_WIDTH));
        end
        bfu_pkg::REG_SRC_HEIGHT: begin
          sh_q <= SHW'(sat_size(13'(cfg_wdata_i[bfu_pkg::SRC_REG_W-1:0]), MAX_SOURCE_HEIGHT));
        end
        bfu_pkg::REG_TGT_WIDTH: begin
          tw_q <= TSW'(sat_size(cfg_wdata_i, MAX_TARGET_SIZE));
        end
        bfu_pkg::REG_TGT_HEIGHT: begin
          th_q <= TSW'(sat_size(cfg_wdata_i, MAX_TARGET_SIZE));
        end
        default: begin
        end
      endcase
    end
  end

  // Every stage moves together unless a result waits at the output.
  logic en;
  logic ov_q;
  assign en         = !ov_q || out_ready_i;
  assign in_ready_o = en;

  // Write decision is made on entry; the write itself lands in the store at the
  // same pipeline position as reads, which keeps requests in order.
  logic wen_in;
  assign wen_in = (opcode_i == bfu_pkg::OP_WRITE) &&
                  (13'(coord_x_i) < 13'(sw_q)) && (13'(coord_y_i) < 13'(sh_q));

  logic                       v_q  [LOC];
  logic                       rd_q [LOC];
  logic                       we_q [LOC];
  logic [XB-1:0]              wx_q [LOC];
  logic [YB-1:0]              wy_q [LOC];
  logic [bfu_pkg::PIX_W-1:0]  wd_q [LOC];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LOC; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (en) begin
      v_q[0] <= in_valid_i;
      for (int k = 1; k < LOC; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_q[0] <= (opcode_i == bfu_pkg::OP_READ);
      we_q[0] <= wen_in;
      wx_q[0] <= XB'(coord_x_i);
      wy_q[0] <= YB'(coord_y_i);
      wd_q[0] <= pixel_in_i;
      for (int k = 1; k < LOC; k++) begin
        rd_q[k] <= rd_q[k-1];
        we_q[k] <= we_q[k-1];
        wx_q[k] <= wx_q[k-1];
        wy_q[k] <= wy_q[k-1];
        wd_q[k] <= wd_q[k-1];
      end
    end
  end

  logic [XB-1:0] x_lo;
  logic [YB-1:0] y_lo;
  logic          x_edge, y_edge;
  logic [bfu_pkg::WEIGHT_W-1:0] x_w, y_w;

  bfu_locate #(
    .MAX_SRC  (MAX_SOURCE_WIDTH),
    .MAX_TGT  (MAX_TARGET_SIZE),
    .DIV_BITS (DIV_BITS)
  ) u_loc_x (
    .clk_i    (clk_i),
    .en_i     (en),
    .pos_i    (coord_x_i),
    .src_i    (sw_q),
    .tgt_i    (tw_q),
    .lo_o     (x_lo),
    .edge_o   (x_edge),
    .weight_o (x_w)
  );

  bfu_locate #(
    .MAX_SRC  (MAX_SOURCE_HEIGHT),
    .MAX_TGT  (MAX_TARGET_SIZE),
    .DIV_BITS (DIV_BITS)
  ) u_loc_y (
    .clk_i    (clk_i),
    .en_i     (en),
    .pos_i    (coord_y_i),
    .src_i    (sh_q),
    .tgt_i    (th_q),
    .lo_o     (y_lo),
    .edge_o   (y_edge),
    .weight_o (y_w)
  );

  logic [bfu_pkg::PIX_W-1:0] p00, p10, p01, p11;

  bfu_store #(
    .MAX_W (MAX_SOURCE_WIDTH),
    .MAX_H (MAX_SOURCE_HEIGHT)
  ) u_store (
    .clk_i    (clk_i),
    .en_i     (en),
    .we_i     (v_q[LOC-1] && we_q[LOC-1]),
    .wx_i     (wx_q[LOC-1]),
    .wy_i     (wy_q[LOC-1]),
    .wdata_i  (wd_q[LOC-1]),
    .x_lo_i   (x_lo),
    .x_edge_i (x_edge),
    .y_lo_i   (y_lo),
    .y_edge_i (y_edge),
    .p00_o    (p00),
    .p10_o    (p10),
    .p01_o    (p01),
    .p11_o    (p11)
  );

  // Weights are registered once to meet the store read; valid follows through the mixes.
  logic [bfu_pkg::WEIGHT_W-1:0] xw_q, yw_q;
  logic                         sv_q, hv_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      xw_q <= x_w;
      yw_q <= y_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
      hv_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      sv_q <= v_q[LOC-1] && rd_q[LOC-1];
      hv_q <= sv_q;
      ov_q <= hv_q;
    end
  end

  bfu_blend u_blend (
    .clk_i (clk_i),
    .en_i  (en),
    .p00_i (p00),
    .p10_i (p10),
    .p01_i (p01),
    .p11_i (p11),
    .wx_i  (xw_q),
    .wy_i  (yw_q),
    .pix_o (pixel_out_o)
  );

  assign out_valid_o = ov_q;

  // The located lower column and row of a read stay inside the configured source frame.
  a_x_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[LOC-1] && rd_q[LOC-1]) |-> (32'(x_lo) < 32'(sw_q)))
    else $error("column neighbor outside source frame");

  a_y_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[LOC-1] && rd_q[LOC-1]) |-> (32'(y_lo) < 32'(sh_q)))
    else $error("row neighbor outside source frame");

  // A clamped edge position never carries a mixing weight.
  a_edge_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[LOC-1] && rd_q[LOC-1]) |-> ((!x_edge || x_w == '0) && (!y_edge || y_w == '0)))
    else $error("edge position with nonzero weight");

  // A stall freezes the request pipeline at the store.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(v_q[LOC-1]) && $stable(sv_q) && $stable(hv_q)))
    else $error("pipeline moved during stall");

endmodule

[sim/bfu_checker.sv]
// Checker for the bilinear frame upscaler: tracks the frame and the sizes, predicts and compares.
module bfu_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bfu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bfu_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic                           opcode_i,
  input  logic [bfu_pkg::COORD_W-1:0]    coord_x_i,
  input  logic [bfu_pkg::COORD_W-1:0]    coord_y_i,
  input  logic [bfu_pkg::PIX_W-1:0]      pixel_in_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [bfu_pkg::PIX_W-1:0]      pixel_out_i,
  output int                             errors_o,
  output int                             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SRC_MAX   = 256;
  localparam int TGT_MAX   = 4096;
  localparam int PIX_W     = bfu_pkg::PIX_W;
  localparam int SRC_REG_W = bfu_pkg::SRC_REG_W;
  localparam int TGT_REG_W = bfu_pkg::TGT_REG_W;

  logic [PIX_W-1:0]     frame_mem [SRC_MAX*SRC_MAX];
  logic [SRC_REG_W-1:0] src_w_q, src_h_q;
  logic [TGT_REG_W-1:0] tgt_w_q, tgt_h_q;
  logic [PIX_W-1:0]     pixel_expect_q [$];

  assign pending_o = pixel_expect_q.size();

  function automatic longint clamp_size(longint v, longint hi);
    return (v < 1) ? 1 : (v > hi) ? hi : v;
  endfunction

  // Maps a destination coordinate to its two source taps and the Q8 weight.
  function automatic void source_pos(input longint pos, input longint src, input longint tgt,
                                     output longint lo, output longint hi,
                                     output longint wt);
    longint num, den, whole, rem;
    num = (2 * pos + 1) * src - tgt;
    den = 2 * tgt;
    lo  = 0;
    wt  = 0;
    if (num > 0) begin
      whole = num / den;
      rem   = num % den;
      if (whole >= src - 1) begin
        lo = src - 1;
      end else begin
        lo = whole;
        wt = (rem * 256 + tgt) / den;
      end
    end
    hi = (lo + 1 < src) ? lo + 1 : lo;
  endfunction

  function automatic logic [PIX_W-1:0] mix_q8(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                              longint wt);
    logic [PIX_W-1:0] r;
    longint s;
    for (int c = 0; c < 3; c++) begin
      s = longint'(a[8*c +: 8]) * (256 - wt) + longint'(b[8*c +: 8]) * wt + 128;
      r[8*c +: 8] = s[15:8];
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] upscaled_pixel(longint cx, longint cy);
    longint sw, sh, tw, th, x0, x1, wx, y0, y1, wy;
    logic [PIX_W-1:0] top, bot;
    sw = clamp_size(src_w_q, SRC_MAX);
    sh = clamp_size(src_h_q, SRC_MAX);
    tw = clamp_size(tgt_w_q, TGT_MAX);
    th = clamp_size(tgt_h_q, TGT_MAX);
    source_pos(cx, sw, tw, x0, x1, wx);
    source_pos(cy, sh, th, y0, y1, wy);
    top = mix_q8(frame_mem[y0*SRC_MAX + x0], frame_mem[y0*SRC_MAX + x1], wx);
    bot = mix_q8(frame_mem[y1*SRC_MAX + x0], frame_mem[y1*SRC_MAX + x1], wx);
    return mix_q8(top, bot, wy);
  endfunction

  task automatic report(string what, logic [PIX_W-1:0] got, logic [PIX_W-1:0] want);
    $display("%0t mismatch %s: got %06h, expected %06h", $realtime, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q  <= SRC_REG_W'(SRC_MAX);
      src_h_q  <= SRC_REG_W'(SRC_MAX);
      tgt_w_q  <= TGT_REG_W'(256);
      tgt_h_q  <= TGT_REG_W'(256);
      errors_o <= 0;
      pixel_expect_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          bfu_pkg::REG_SRC_WIDTH:  src_w_q <= cfg_wdata_i[SRC_REG_W-1:0];
          bfu_pkg::REG_SRC_HEIGHT: src_h_q <= cfg_wdata_i[SRC_REG_W-1:0];
          bfu_pkg::REG_TGT_WIDTH:  tgt_w_q <= cfg_wdata_i;
          bfu_pkg::REG_TGT_HEIGHT: tgt_h_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (opcode_i == bfu_pkg::OP_WRITE) begin
          if (coord_x_i < clamp_size(src_w_q, SRC_MAX) &&
              coord_y_i < clamp_size(src_h_q, SRC_MAX))
            frame_mem[coord_y_i*SRC_MAX + coord_x_i] = pixel_in_i;
        end else begin
          pixel_expect_q.push_back(upscaled_pixel(coord_x_i, coord_y_i));
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (pixel_expect_q.size() == 0) begin
          report("unexpected pixel_out", pixel_out_i, '0);
        end else begin
          if (pixel_out_i !== pixel_expect_q[0])
            report("pixel_out", pixel_out_i, pixel_expect_q[0]);
          void'(pixel_expect_q.pop_front());
        end
      end
    end
  end

endmodule

[sim/testbench.sv]
// Top of the upscaler testbench: clock, reset, request stimulus, idling and the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES  = 8;
  localparam int RANDOM_OPS  = 40;
  localparam int DRAIN_WAIT  = 24;      // covers the pipeline depth at default sizes
  localparam int IDLE_LIMIT  = 5000;
  localparam int COORD_W     = bfu_pkg::COORD_W;
  localparam int PIX_W       = bfu_pkg::PIX_W;
  localparam int CFG_IDX_W   = bfu_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = bfu_pkg::CFG_DATA_W;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  opcode_i = bfu_pkg::OP_WRITE;
  logic [COORD_W-1:0]    coord_x_i = '0;
  logic [COORD_W-1:0]    coord_y_i = '0;
  logic [PIX_W-1:0]      pixel_in_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [PIX_W-1:0]      pixel_out_o;
  int                    errors;
  int                    pending;
  int                    requests_taken = 0;
  int                    idle_cycles = 0;
  bit                    calm_sender = 1'b0;

  // Source width, source height, target width, target height per phase. Some values lie
  // outside the supported range on purpose so that the saturation of the sizes gets used.
  int phase_cfg [NUM_PHASES][4] = '{
    '{8, 8, 8, 8},          // equal sizes: an exact copy
    '{8, 8, 16, 16},
    '{511, 0, 4096, 13},    // widest source frame, a single source row
    '{0, 300, 37, 8191},    // a single source column, source and target height saturate
    '{13, 11, 100, 77},
    '{20, 10, 20, 45},
    '{17, 9, 8, 8},         // target smaller than source
    '{9, 16, 4095, 1000}
  };

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bilinear_frame_upscaler dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .opcode_i, .coord_x_i, .coord_y_i, .pixel_in_i,
    .out_valid_o, .out_ready_i, .pixel_out_o
  );

  bfu_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .opcode_i, .coord_x_i, .coord_y_i, .pixel_in_i,
    .out_valid_i(out_valid_o), .out_ready_i, .pixel_out_i(pixel_out_o),
    .errors_o(errors), .pending_o(pending)
  );

  // Counts accepted requests and guards against a hung handshake on either side.
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) requests_taken <= requests_taken + 1;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** bilinear_frame_upscaler: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side. It alternates between stretches that always accept and stretches with
  // random stalls. Once, while reads of the first phase are under way, it holds off long
  // enough that the pipeline fills and the block has to push back on its input.
  initial begin : result_side
    int stall_left;
    int mode_left;
    bit stalling;
    bit long_hold_done;
    stall_left = 0;
    mode_left = 0;
    stalling = 1'b0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && requests_taken > 80) begin
        long_hold_done = 1'b1;
        stall_left = 300;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(400, 50);
        stalling = ($urandom_range(3, 0) != 0);
      end
      mode_left--;
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (stalling && $urandom_range(9, 0) < 3) begin
        stall_left = ($urandom_range(19, 0) == 0) ? $urandom_range(40, 10)
                                                  : $urandom_range(3, 0);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Offers one request and returns at the edge where it is taken. Valid only drops when
  // there is a gap, so it never falls and rises within the same step.
  task automatic send_request(logic op, int x, int y, logic [PIX_W-1:0] pix);
    int gap;
    gap = 0;
    if (!calm_sender && $urandom_range(9, 0) < 3)
      gap = ($urandom_range(24, 0) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    coord_x_i  <= COORD_W'(x);
    coord_y_i  <= COORD_W'(y);
    pixel_in_i <= pix;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Sizes change only with the pipeline empty, plus a margin for a write still in flight.
  task automatic set_sizes(int sw, int sh, int tw, int th);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= bfu_pkg::REG_SRC_WIDTH;  cfg_wdata_i <= CFG_DATA_W'(sw);
    @(posedge clk_i);
    cfg_index_i <= bfu_pkg::REG_SRC_HEIGHT; cfg_wdata_i <= CFG_DATA_W'(sh);
    @(posedge clk_i);
    cfg_index_i <= bfu_pkg::REG_TGT_WIDTH;  cfg_wdata_i <= CFG_DATA_W'(tw);
    @(posedge clk_i);
    cfg_index_i <= bfu_pkg::REG_TGT_HEIGHT; cfg_wdata_i <= CFG_DATA_W'(th);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : request_side
    int sw, sh, tw, th, pick, x, y;
    logic [PIX_W-1:0] pix;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_sizes(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
      sw = (phase_cfg[p][0] > 256) ? 256 : (phase_cfg[p][0] < 1) ? 1 : phase_cfg[p][0];
      sh = (phase_cfg[p][1] > 256) ? 256 : (phase_cfg[p][1] < 1) ? 1 : phase_cfg[p][1];
      tw = (phase_cfg[p][2] > 4096) ? 4096 : (phase_cfg[p][2] < 1) ? 1 : phase_cfg[p][2];
      th = (phase_cfg[p][3] > 4096) ? 4096 : (phase_cfg[p][3] < 1) ? 1 : phase_cfg[p][3];
      calm_sender = (p % 3 == 1);

      // Every entry a read could touch is written before the first read of the phase.
      for (int r = 0; r < sh; r++)
        for (int c = 0; c < sw; c++) begin
          pix = PIX_W'($urandom());
          if (p == 0 && r == 0 && c == 0) pix = '0;
          if (p == 0 && r == sh - 1 && c == sw - 1) pix = '1;
          send_request(bfu_pkg::OP_WRITE, c, r, pix);
        end

      if (p < 2) begin
        // Corners, far outside the target frame, and ignored writes outside the source.
        send_request(bfu_pkg::OP_READ, 0, 0, '0);
        send_request(bfu_pkg::OP_READ, tw - 1, th - 1, '1);
        send_request(bfu_pkg::OP_READ, 4095, 4095, '0);
        send_request(bfu_pkg::OP_READ, 0, 4095, '0);
        send_request(bfu_pkg::OP_READ, 4095, 0, '0);
        send_request(bfu_pkg::OP_READ, tw / 2, th / 3, '0);
        send_request(bfu_pkg::OP_WRITE, sw, 0, '1);
        send_request(bfu_pkg::OP_WRITE, 0, sh, '1);
        send_request(bfu_pkg::OP_WRITE, 4095, 4095, '1);
        send_request(bfu_pkg::OP_READ, tw - 1, 0, '0);
        send_request(bfu_pkg::OP_READ, 0, th - 1, '0);
      end

      for (int i = 0; i < RANDOM_OPS; i++) begin
        pick = $urandom_range(99, 0);
        pix = PIX_W'($urandom());
        if (pick < 60) begin
          send_request(bfu_pkg::OP_READ, $urandom_range(tw - 1, 0), $urandom_range(th - 1, 0),
                       pix);
        end else if (pick < 72) begin
          send_request(bfu_pkg::OP_READ, $urandom_range(4095, 0), $urandom_range(4095, 0), pix);
        end else if (pick < 92) begin
          send_request(bfu_pkg::OP_WRITE, $urandom_range(sw - 1, 0), $urandom_range(sh - 1, 0),
                       pix);
        end else begin
          x = $urandom_range(4095, 0);
          y = $urandom_range(4095, 0);
          send_request(bfu_pkg::OP_WRITE, x, y, pix);
        end
      end
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0) begin
      $display("** bilinear_frame_upscaler: PASSED **");
    end else begin
      $display("** bilinear_frame_upscaler: FAILED **");
    end
    $finish;
  end

endmodule
